[rtl/spq2_pkg.sv]
`timescale 1ns / 1ps

package spq2_pkg;

    // Action codes carried on the input tuser bit.
    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_DONE    = 1'b1;

    // Arrival class codes as they appear on the input.
    localparam logic [1:0] PCLS_FAULT = 2'd0;
    localparam logic [1:0] PCLS_TELEM = 2'd1;

    // Class codes of a stored or served packet.
    localparam logic CLASS_FAULT = 1'b0;
    localparam logic CLASS_TELEM = 1'b1;

    localparam int TAG_FIELD_W   = 16;
    localparam int STAMP_W       = 32;
    localparam int IN_TDATA_W    = 88;
    localparam int OUT_TDATA_W   = 72;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    // Declared from the highest bit down, so the last member sits at bit 0.
    typedef struct packed {
        logic        spurious_done;
        logic [5:0]  peak_occupancy;
        logic [4:0]  telemetry_level;
        logic [4:0]  fault_level;
        logic        server_busy;
        logic [15:0] start_tag;
        logic        start_class;
        logic        start_valid;
        logic [31:0] done_delay;
        logic        done_class;
        logic        done_valid;
        logic        accepted;
    } t_result;

endpackage

[rtl/strict_priority_two_class_queue.sv]
`timescale 1ns / 1ps

// Two-class strict-priority queue with a single server. Each input word is
// either a packet arrival (tuser 0) or a service-done event (tuser 1), and
// each produces exactly one result word. Fault and telemetry packets wait in
// two circular buffers of QUEUE_DEPTH entries, each a synchronous memory;
// the server always takes the fault head first. A word that pops a stored
// packet has its result valid after a memory read and then a result load;
// any other word has it valid in the cycle after acceptance. The next word is
// accepted once the previous result has been taken by the sink. The registered
// read of the queue memories is what sets the longer path. An arrival
// that meets an idle server is forwarded straight into service.
module strict_priority_two_class_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: packet_class[1:0], packet_tag[17:2], arrival_stamp[49:18],
    // now_time[81:50], zero pad above.
    input  logic [spq2_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser: action.
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: accepted, done_valid, done_class, done_delay[31:0], start_valid,
    // start_class, start_tag[15:0], server_busy, fault_level[4:0],
    // telemetry_level[4:0], peak_occupancy[5:0], spurious_done, zero pad.
    output logic [spq2_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int TW  = (TAG_BITS < spq2_pkg::TAG_FIELD_W) ? TAG_BITS
                                                            : spq2_pkg::TAG_FIELD_W;
    localparam int EW  = TW + spq2_pkg::STAMP_W;
    localparam int HW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PW  = CW + 1;
    localparam int PKW = $clog2(2 * QUEUE_DEPTH + 1);

    localparam logic [CW-1:0] DEPTH_C    = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] DEPTH_P    = PW'(QUEUE_DEPTH);
    localparam logic [HW-1:0] LAST_HEAD  = HW'(QUEUE_DEPTH - 1);

    // Input fields.
    logic                         in_action;
    logic [1:0]                   in_class;
    logic [TW-1:0]                in_tag;
    logic [spq2_pkg::STAMP_W-1:0] in_stamp;
    logic [spq2_pkg::STAMP_W-1:0] in_now;

    assign in_action = i_s_axis_tuser;
    assign in_class  = i_s_axis_tdata[1:0];
    assign in_tag    = TW'(i_s_axis_tdata[17:2]);
    assign in_stamp  = i_s_axis_tdata[49:18];
    assign in_now    = i_s_axis_tdata[81:50];

    // Control state.
    spq2_pkg::t_state r_state;
    logic             r_out_valid;
    logic [HW-1:0]    r_f_head, r_t_head;
    logic [CW-1:0]    r_f_cnt, r_t_cnt;
    logic             r_busy;
    logic [PKW-1:0]   r_peak;

    // Payload.
    spq2_pkg::t_result            r_out;
    logic                         r_srv_class;
    logic [spq2_pkg::STAMP_W-1:0] r_srv_stamp;
    logic                         r_rd_sel;

    // Queue memories.
    logic [EW-1:0] r_fault_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_telem_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_fault_rd, r_telem_rd;

    // Next values.
    spq2_pkg::t_result            n_out;
    logic [HW-1:0]                n_f_head, n_t_head;
    logic [CW-1:0]                n_f_cnt, n_t_cnt;
    logic                         n_busy;
    logic [PKW-1:0]               n_peak;
    logic                         n_srv_class;
    logic [spq2_pkg::STAMP_W-1:0] n_srv_stamp;

    logic          acc;
    logic          push_f, push_t;
    logic          pop_read;
    logic          pop_sel;
    logic [HW-1:0] f_head_inc, t_head_inc;
    logic [PW-1:0] f_pos_sum, t_pos_sum;
    logic [HW-1:0] f_wpos, t_wpos;
    logic [PKW-1:0] total;
    logic [EW-1:0] rd_entry;

    assign o_s_axis_tready = (r_state == spq2_pkg::S_IDLE) && !r_out_valid;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out};

    assign f_head_inc = (r_f_head == LAST_HEAD) ? '0 : r_f_head + HW'(1);
    assign t_head_inc = (r_t_head == LAST_HEAD) ? '0 : r_t_head + HW'(1);

    // The tail position is head plus count, which stays below twice the depth.
    assign f_pos_sum = PW'(r_f_head) + PW'(r_f_cnt);
    assign t_pos_sum = PW'(r_t_head) + PW'(r_t_cnt);
    assign f_wpos    = (f_pos_sum >= DEPTH_P) ? HW'(f_pos_sum - DEPTH_P) : HW'(f_pos_sum);
    assign t_wpos    = (t_pos_sum >= DEPTH_P) ? HW'(t_pos_sum - DEPTH_P) : HW'(t_pos_sum);

    assign rd_entry = (r_rd_sel == spq2_pkg::CLASS_TELEM) ? r_telem_rd : r_fault_rd;

    always_comb begin
        n_out       = '0;
        n_f_head    = r_f_head;
        n_t_head    = r_t_head;
        n_f_cnt     = r_f_cnt;
        n_t_cnt     = r_t_cnt;
        n_busy      = r_busy;
        n_peak      = r_peak;
        n_srv_class = r_srv_class;
        n_srv_stamp = r_srv_stamp;
        push_f      = 1'b0;
        push_t      = 1'b0;
        pop_read    = 1'b0;
        pop_sel     = spq2_pkg::CLASS_FAULT;
        total       = '0;

        if (in_action == spq2_pkg::ACT_ARRIVAL) begin
            if (in_class == spq2_pkg::PCLS_FAULT && r_f_cnt != DEPTH_C) begin
                push_f  = 1'b1;
                n_f_cnt = r_f_cnt + CW'(1);
            end else if (in_class == spq2_pkg::PCLS_TELEM && r_t_cnt != DEPTH_C) begin
                push_t  = 1'b1;
                n_t_cnt = r_t_cnt + CW'(1);
            end
            if (push_f || push_t) begin
                n_out.accepted = 1'b1;
                total = PKW'(n_f_cnt) + PKW'(n_t_cnt);
                if (total > r_peak) begin
                    n_peak = total;
                end
                // An idle server implies both queues are empty, so the new
                // packet is the head and goes straight into service.
                if (!r_busy) begin
                    n_busy            = 1'b1;
                    n_out.start_valid = 1'b1;
                    n_out.start_class = push_t ? spq2_pkg::CLASS_TELEM
                                               : spq2_pkg::CLASS_FAULT;
                    n_out.start_tag   = 16'(in_tag);
                    n_srv_class       = n_out.start_class;
                    n_srv_stamp       = in_stamp;
                    if (push_f) begin
                        n_f_cnt  = r_f_cnt;
                        n_f_head = f_head_inc;
                    end else begin
                        n_t_cnt  = r_t_cnt;
                        n_t_head = t_head_inc;
                    end
                end
            end
        end else if (r_busy) begin
            n_out.done_valid = 1'b1;
            n_out.done_class = r_srv_class;
            n_out.done_delay = in_now - r_srv_stamp;
            if (r_f_cnt != '0) begin
                n_f_cnt           = r_f_cnt - CW'(1);
                n_f_head          = f_head_inc;
                pop_read          = 1'b1;
                pop_sel           = spq2_pkg::CLASS_FAULT;
                n_out.start_valid = 1'b1;
                n_out.start_class = spq2_pkg::CLASS_FAULT;
                n_srv_class       = spq2_pkg::CLASS_FAULT;
            end else if (r_t_cnt != '0) begin
                n_t_cnt           = r_t_cnt - CW'(1);
                n_t_head          = t_head_inc;
                pop_read          = 1'b1;
                pop_sel           = spq2_pkg::CLASS_TELEM;
                n_out.start_valid = 1'b1;
                n_out.start_class = spq2_pkg::CLASS_TELEM;
                n_srv_class       = spq2_pkg::CLASS_TELEM;
            end else begin
                n_busy = 1'b0;
            end
        end else begin
            n_out.spurious_done = 1'b1;
        end

        n_out.server_busy     = n_busy;
        n_out.fault_level     = 5'(n_f_cnt);
        n_out.telemetry_level = 5'(n_t_cnt);
        n_out.peak_occupancy  = 6'(n_peak);
    end

    // Queue memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (acc && push_f) begin
            r_fault_mem[f_wpos] <= {in_tag, in_stamp};
        end
        if (acc) begin
            r_fault_rd <= r_fault_mem[r_f_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && push_t) begin
            r_telem_mem[t_wpos] <= {in_tag, in_stamp};
        end
        if (acc) begin
            r_telem_rd <= r_telem_mem[r_t_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq2_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_f_head    <= '0;
            r_t_head    <= '0;
            r_f_cnt     <= '0;
            r_t_cnt     <= '0;
            r_busy      <= 1'b0;
            r_peak      <= '0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                spq2_pkg::S_IDLE: begin
                    if (acc) begin
                        r_f_head <= n_f_head;
                        r_t_head <= n_t_head;
                        r_f_cnt  <= n_f_cnt;
                        r_t_cnt  <= n_t_cnt;
                        r_busy   <= n_busy;
                        r_peak   <= n_peak;
                        if (pop_read) begin
                            r_state <= spq2_pkg::S_READ;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                spq2_pkg::S_READ: begin
                    r_out_valid <= 1'b1;
                    r_state     <= spq2_pkg::S_IDLE;
                end
                default: begin
                    r_state <= spq2_pkg::S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out       <= n_out;
            r_srv_class <= n_srv_class;
            r_srv_stamp <= n_srv_stamp;
            r_rd_sel    <= pop_sel;
        end else if (r_state == spq2_pkg::S_READ) begin
            // The popped head arrives from memory in the cycle after acceptance.
            r_out.start_tag <= 16'(rd_entry[EW-1:spq2_pkg::STAMP_W]);
            r_srv_stamp     <= rd_entry[spq2_pkg::STAMP_W-1:0];
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_f_cnt == '0 && r_t_cnt == '0))
        else $error("server idle while packets wait");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_cnt <= DEPTH_C) && (r_t_cnt <= DEPTH_C))
        else $error("queue count beyond depth");

    a_read_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spq2_pkg::S_READ) |-> !r_out_valid)
        else $error("result pending during memory read");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spq2_pkg::S_READ) |=> (r_out_valid && r_state == spq2_pkg::S_IDLE))
        else $error("memory read did not produce a result");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_out_valid || r_state == spq2_pkg::S_READ))
        else $error("accepted word produced no result");
`endif

endmodule
